// File: rtl/core/quaternion_product_and_difference_defines.svh
`ifndef QUATERNION_PRODUCT_AND_DIFFERENCE_DEFINES_SVH
`define QUATERNION_PRODUCT_AND_DIFFERENCE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define QPD_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define QPD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/core/qpd_pkg.sv
package qpd_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Components of a quaternion, in port order
    localparam int NUM_COMP = 4;

    // Command codes
    localparam logic CMD_PRODUCT = 1'b0;
    localparam logic CMD_DIFF    = 1'b1;

    // Result component c sums a[k] * b[c ^ k] over k. Bit k set: subtract that term.
    // Plain Hamilton product a*b.
    localparam logic [NUM_COMP-1:0] NEG_PROD [NUM_COMP] = '{
        4'b1110, 4'b1000, 4'b0010, 4'b0100
    };
    // Product with the conjugate of b; the w row is then the dot product.
    localparam logic [NUM_COMP-1:0] NEG_DIFF [NUM_COMP] = '{
        4'b0000, 4'b0101, 4'b1001, 4'b0011
    };

endpackage

// File: rtl/core/qpd_mult.sv
module qpd_mult #(
    parameter int COMP_WIDTH = qpd_pkg::COMP_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [COMP_WIDTH-1:0]  a [qpd_pkg::NUM_COMP],
    input  logic signed [COMP_WIDTH-1:0]  b [qpd_pkg::NUM_COMP],
    output logic signed [2*COMP_WIDTH-1:0] prod [qpd_pkg::NUM_COMP][qpd_pkg::NUM_COMP]
);
    import qpd_pkg::*;

    // Form every cross product a[i] * b[j] and register it
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_COMP; i++) begin
                for (int j = 0; j < NUM_COMP; j++) begin
                    prod[i][j] <= a[i] * b[j];
                end
            end
        end
    end

endmodule

// File: rtl/core/quaternion_product_and_difference.sv
// Quaternion product and rotation difference, signed fixed point.
// Input channel s_: one request carries quaternions a and b in s_tdata and the
// command in s_tuser (0 = Hamilton product a*b, 1 = difference a*conj(+/-b), where
// b is negated first when the dot product a.b is negative).
// Result channel m_: the rounded (half up) and saturated quaternion in m_tdata,
// and in m_tuser a flag that any component was clipped to the signed range.
// Stages: input register, multiply, four-term sum, sign fix and rounding,
// shift and saturate.
// Throughput: one request per cycle while the receiver does not stall, set by the
// five register stages with one multiplier per cross product (sixteen in all).
// Reset clears the valid bits of all stages; no result is pending afterwards.
// When the receiver stalls, the output register holds its result and each stage
// only moves forward into an empty or advancing stage, so bubbles close up and
// s_tready stays high until all five stages hold a result.
`include "quaternion_product_and_difference_defines.svh"

module quaternion_product_and_difference #(
    parameter int COMP_WIDTH = qpd_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qpd_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input request
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [8*COMP_WIDTH-1:0]   s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [0:0]                s_tuser,   // command
    // Result
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [4*COMP_WIDTH-1:0]   m_tdata,   // r_w, r_x, r_y, r_z
    output logic [0:0]                m_tuser    // saturated
);
    import qpd_pkg::*;

    localparam int W      = COMP_WIDTH;
    // exact sum of four products, with room for the rounding half and the
    // shifted value plus one guard bit for the range check
    localparam int SW     = (2 * COMP_WIDTH + 2 > FRAC_BITS + COMP_WIDTH + 1)
                          ? 2 * COMP_WIDTH + 2 : FRAC_BITS + COMP_WIDTH + 1;
    localparam int NSTAGE = 5;
    localparam logic [SW-1:0] HALF    = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic [SW-1:0] HALF_P1 = HALF + {{(SW-1){1'b0}}, 1'b1};

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] adv;

    logic                   cmd1_reg, cmd2_reg, cmd3_reg;
    logic signed [W-1:0]    a1_reg [NUM_COMP];
    logic signed [W-1:0]    b1_reg [NUM_COMP];
    logic signed [W-1:0]    a_in   [NUM_COMP];
    logic signed [W-1:0]    b_in   [NUM_COMP];
    logic signed [2*W-1:0]  prod2  [NUM_COMP][NUM_COMP];
    logic signed [SW-1:0]   sum3_next [NUM_COMP];
    logic signed [SW-1:0]   sum3_reg  [NUM_COMP];
    logic                   neg3;
    logic [SW-1:0]          rnd4_next [NUM_COMP];
    logic [SW-1:0]          rnd4_reg  [NUM_COMP];
    logic [W-1:0]           r5_next [NUM_COMP];
    logic [W-1:0]           r5_reg  [NUM_COMP];
    logic                   sat5_next, sat5_reg;

    // Each stage advances when it is empty or the next one advances
    always_comb begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Unpack the input request
    always_comb begin
        for (int i = 0; i < NUM_COMP; i++) begin
            a_in[i] = $signed(s_tdata[i*W +: W]);
            b_in[i] = $signed(s_tdata[(NUM_COMP+i)*W +: W]);
        end
    end

    // Stage 1: input register
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            cmd1_reg <= s_tuser[0];
            a1_reg   <= a_in;
            b1_reg   <= b_in;
        end
    end

    // Stage 2: cross products
    qpd_mult #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_mult (
        .aclk (aclk),
        .en   (adv[1]),
        .a    (a1_reg),
        .b    (b1_reg),
        .prod (prod2)
    );

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            cmd2_reg <= cmd1_reg;
        end
    end

    // Stage 3: signed four-term sums, w row doubles as the dot product for a difference
    always_comb begin
        logic [NUM_COMP-1:0] mask;
        logic signed [SW-1:0] term;
        for (int c = 0; c < NUM_COMP; c++) begin
            mask         = (cmd2_reg == CMD_DIFF) ? NEG_DIFF[c] : NEG_PROD[c];
            sum3_next[c] = '0;
            for (int k = 0; k < NUM_COMP; k++) begin
                term = SW'(prod2[k][2'(c) ^ 2'(k)]);
                if (mask[k]) begin
                    term = -term;
                end
                sum3_next[c] = sum3_next[c] + term;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            cmd3_reg <= cmd2_reg;
            sum3_reg <= sum3_next;
        end
    end

    // Stage 4: for a difference, negate when the dot product is negative; fold in the rounding half
    assign neg3 = (cmd3_reg == CMD_DIFF) && sum3_reg[0][SW-1];

    always_comb begin
        for (int c = 0; c < NUM_COMP; c++) begin
            rnd4_next[c] = neg3 ? (~sum3_reg[c] + HALF_P1) : (sum3_reg[c] + HALF);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            rnd4_reg <= rnd4_next;
        end
    end

    // Stage 5: drop fraction bits and clip to the component range
    always_comb begin
        logic [SW-FRAC_BITS-1:0] sh;
        logic                    fits;
        sat5_next = 1'b0;
        for (int c = 0; c < NUM_COMP; c++) begin
            sh   = rnd4_reg[c][SW-1:FRAC_BITS];
            fits = (&sh[SW-FRAC_BITS-1:W-1]) || !(|sh[SW-FRAC_BITS-1:W-1]);
            if (fits) begin
                r5_next[c] = sh[W-1:0];
            end else begin
                r5_next[c] = sh[SW-FRAC_BITS-1] ? {1'b1, {(W-1){1'b0}}}
                                                : {1'b0, {(W-1){1'b1}}};
                sat5_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            r5_reg   <= r5_next;
            sat5_reg <= sat5_next;
        end
    end

    // Drive the result channel
    assign m_tvalid   = valid_reg[NSTAGE-1];
    assign m_tdata    = {r5_reg[3], r5_reg[2], r5_reg[1], r5_reg[0]};
    assign m_tuser[0] = sat5_reg;

    `QPD_ASSERT_SAME(a_full_when_blocked, !s_tready, &valid_reg,
        "input blocked while a pipeline stage is empty")
    `QPD_ASSERT_NEXT(a_hold_stalled, valid_reg[2] && !adv[2], valid_reg[2],
        "stalled request dropped from the sum stage")
    `QPD_ASSERT_NEXT(a_move_forward, valid_reg[2] && adv[3], valid_reg[3],
        "advancing request lost between sum and rounding stages")
    `QPD_ASSERT_SAME(a_prod_no_negate, valid_reg[2] && cmd3_reg == CMD_PRODUCT, !neg3,
        "product command took the difference sign flip")

endmodule
